@@ rtl/wvq_pkg.sv @@
// shared types and constants for the windowed class vote qualifier
package wvq_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 8;

    localparam int CLASS_W   = 4;
    localparam int THRESH_W  = 4;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [THRESH_W-1:0]  RST_PRI_THRESH      = 4'd5;
    localparam logic [THRESH_W-1:0]  RST_PRI_HELD_THRESH = 4'd7;
    localparam logic [THRESH_W-1:0]  RST_SEC_THRESH      = 4'd3;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_LIMIT   = 16'd50;

    localparam logic [TIMEOUT_W-1:0] IDLE_COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRI_THRESH      = 3'd0,
        CFG_PRI_HELD_THRESH = 3'd1,
        CFG_SEC_THRESH      = 3'd2,
        CFG_TIMEOUT_LIMIT   = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_COUNT = 2'd1,
        ST_VOTE  = 2'd2
    } t_state;

    typedef struct packed {
        logic [THRESH_W-1:0]  pri_thresh;
        logic [THRESH_W-1:0]  pri_held_thresh;
        logic [THRESH_W-1:0]  sec_thresh;
        logic [TIMEOUT_W-1:0] timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic                primary_stable;
        logic [CLASS_W-1:0]  held_class;
        logic                servo_pulse;
        logic                motor_pulse;
        logic                detected;
        logic                disarm;
    } t_result;

endpackage

@@ rtl/wvq_cell.sv @@
// one window cell: holds one class entry and adds its match to the passing count
module wvq_cell #(
    parameter int CW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [wvq_pkg::CLASS_W-1:0] i_entry,
    input  logic [wvq_pkg::CLASS_W-1:0] i_sample,
    input  logic [CW-1:0]               i_count,
    output logic [wvq_pkg::CLASS_W-1:0] o_entry,
    output logic [CW-1:0]               o_count
);

    logic [wvq_pkg::CLASS_W-1:0] r_entry;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;

    // entries reset to class none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign n_count = i_count + CW'(r_entry == i_sample);

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
    end

    assign o_entry = r_entry;
    assign o_count = r_count;

endmodule

@@ rtl/wvq_vote.sv @@
// vote thresholds, held class, detected flag and idle timeout
module wvq_vote #(
    parameter int CW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  logic [CW-1:0]               i_matches,
    input  logic [wvq_pkg::CLASS_W-1:0] i_sample,
    input  logic                        i_armed,
    input  wvq_pkg::t_cfg               i_cfg,
    output wvq_pkg::t_result            o_result
);

    localparam int CMPW = (CW > wvq_pkg::THRESH_W) ? CW : wvq_pkg::THRESH_W;

    logic                                r_held_mode;
    logic [wvq_pkg::CLASS_W-1:0]         r_latched;
    logic                                r_detect;
    logic [wvq_pkg::TIMEOUT_W-1:0]       r_idle;

    logic                                n_held_mode;
    logic [wvq_pkg::CLASS_W-1:0]         n_latched;
    logic                                n_detect;
    logic [wvq_pkg::TIMEOUT_W-1:0]       n_idle;

    logic [wvq_pkg::THRESH_W-1:0]        need1;
    logic                                pass1;
    logic                                pass2;
    logic                                disarm;
    logic                                non_none;

    always_comb begin
        non_none  = (i_sample != '0);
        need1     = r_held_mode ? i_cfg.pri_held_thresh : i_cfg.pri_thresh;
        pass1     = CMPW'(i_matches) >= CMPW'(need1);
        pass2     = CMPW'(i_matches) >= CMPW'(i_cfg.sec_thresh);

        n_held_mode = r_held_mode;
        n_latched   = r_latched;
        n_idle      = r_idle;
        n_detect    = r_detect;
        disarm      = 1'b0;

        if (pass1) begin
            n_latched   = i_sample;
            n_held_mode = non_none;
            n_idle      = '0;
        end
        if (pass2) begin
            n_detect = non_none;
        end
        // idle timeout runs only while armed and nothing detected
        if (!n_detect && i_armed) begin
            if (n_idle != wvq_pkg::IDLE_COUNT_MAX) begin
                n_idle = n_idle + 1'b1;
            end
            if (n_idle > i_cfg.timeout_limit) begin
                disarm = 1'b1;
                n_idle = '0;
            end
        end

        o_result.primary_stable = pass1;
        o_result.held_class     = n_latched;
        o_result.servo_pulse    = pass1 && non_none;
        o_result.motor_pulse    = pass2;
        o_result.detected       = n_detect;
        o_result.disarm         = disarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_mode <= 1'b0;
            r_latched   <= '0;
            r_detect    <= 1'b0;
            r_idle      <= '0;
        end else if (i_commit) begin
            r_held_mode <= n_held_mode;
            r_latched   <= n_latched;
            r_detect    <= n_detect;
            r_idle      <= n_idle;
        end
    end

endmodule

@@ rtl/windowed_class_vote_qualifier.sv @@
// top level of the windowed class vote qualifier
// One sample transfer at a time. The accepted class shifts into a chain of
// WINDOW_DEPTH cells (the window, oldest entry falls off the far end; the match
// count does not depend on entry order, so this is equivalent to a ring). A
// match count then ripples down the chain, one cell per cycle, each cell adding
// one when its entry equals the sample. Once the count has passed every cell,
// the far end holds the total, and the vote stage compares it against the
// thresholds, updates held class, detected flag and idle counter, and loads
// the result register. The result is ready when the count has run the length
// of the chain and the vote stage commits; the commit waits while the result
// register is still full. A new sample is taken only after the previous one
// has been voted. The input side is free again as soon as the result
// register is loaded, so the next sample may be taken while a result still
// waits for its output transfer.
// Configuration writes are always accepted (ready tied high); index beyond the
// register list is ignored. No clearing pass: window entries reset directly.
module windowed_class_vote_qualifier #(
    parameter int WINDOW_DEPTH = wvq_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wvq_pkg::CLASS_W-1:0]    i_sample_class,
    input  logic                           i_armed,

    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_primary_stable,
    output logic [wvq_pkg::CLASS_W-1:0]    o_held_class,
    output logic                           o_servo_pulse,
    output logic                           o_motor_pulse,
    output logic                           o_detected,
    output logic                           o_disarm,

    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wvq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wvq_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // count width holds 0..WINDOW_DEPTH, step counter indexes the chain
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(WINDOW_DEPTH - 1);

    // config registers
    wvq_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pri_thresh      <= wvq_pkg::RST_PRI_THRESH;
            r_cfg.pri_held_thresh <= wvq_pkg::RST_PRI_HELD_THRESH;
            r_cfg.sec_thresh      <= wvq_pkg::RST_SEC_THRESH;
            r_cfg.timeout_limit   <= wvq_pkg::RST_TIMEOUT_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (wvq_pkg::t_cfg_idx'(i_cfg_index))
                wvq_pkg::CFG_PRI_THRESH:
                    r_cfg.pri_thresh <= i_cfg_data[wvq_pkg::THRESH_W-1:0];
                wvq_pkg::CFG_PRI_HELD_THRESH:
                    r_cfg.pri_held_thresh <= i_cfg_data[wvq_pkg::THRESH_W-1:0];
                wvq_pkg::CFG_SEC_THRESH:
                    r_cfg.sec_thresh <= i_cfg_data[wvq_pkg::THRESH_W-1:0];
                wvq_pkg::CFG_TIMEOUT_LIMIT:
                    r_cfg.timeout_limit <= i_cfg_data[wvq_pkg::TIMEOUT_W-1:0];
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // control state
    wvq_pkg::t_state             r_state, n_state;
    logic [SW-1:0]               r_step, n_step;
    logic [wvq_pkg::CLASS_W-1:0] r_sample;
    logic                        r_armed;
    logic                        r_out_valid, n_out_valid;
    wvq_pkg::t_result            r_out;

    logic             in_xfer;
    logic             commit;
    wvq_pkg::t_result vote_result;

    assign o_in_ready = (r_state == wvq_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    // sample and armed flag held for the whole item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= i_sample_class;
            r_armed  <= i_armed;
        end
    end

    // cell chain: entries shift right on a sample transfer, counts ripple right
    logic [wvq_pkg::CLASS_W-1:0] entry_link [WINDOW_DEPTH+1];
    logic [CW-1:0]               count_link [WINDOW_DEPTH+1];

    assign entry_link[0] = i_sample_class;
    assign count_link[0] = '0;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        wvq_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (in_xfer),
            .i_entry  (entry_link[g]),
            .i_sample (r_sample),
            .i_count  (count_link[g]),
            .o_entry  (entry_link[g+1]),
            .o_count  (count_link[g+1])
        );
    end

    // far-end entry drops out of the window
    logic [wvq_pkg::CLASS_W-1:0] dropped_entry;
    assign dropped_entry = entry_link[WINDOW_DEPTH];

    wvq_vote #(
        .CW (CW)
    ) u_vote (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_commit  (commit),
        .i_matches (count_link[WINDOW_DEPTH]),
        .i_sample  (r_sample),
        .i_armed   (r_armed),
        .i_cfg     (r_cfg),
        .o_result  (vote_result)
    );

    // sequencer: idle -> count down the chain -> vote into result register
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        commit      = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            wvq_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = wvq_pkg::ST_COUNT;
                    n_step  = '0;
                end
            end
            wvq_pkg::ST_COUNT: begin
                if (r_step == LAST_STEP) begin
                    n_state = wvq_pkg::ST_VOTE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            wvq_pkg::ST_VOTE: begin
                // result register free, or freed by a transfer this cycle
                if (!r_out_valid || i_out_ready) begin
                    commit      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = wvq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wvq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wvq_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out <= vote_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_primary_stable = r_out.primary_stable;
    assign o_held_class     = r_out.held_class;
    assign o_servo_pulse    = r_out.servo_pulse;
    assign o_motor_pulse    = r_out.motor_pulse;
    assign o_detected       = r_out.detected;
    assign o_disarm         = r_out.disarm;

    // the dropped entry has no consumer beyond the chain end
    logic unused_drop;
    assign unused_drop = ^dropped_entry;

endmodule
